// ===== src/agr_pkg.sv =====
// Shared constants, types and codes of the audio group router with crossfade.
`default_nettype none
package agr_pkg;

  localparam int CHANNELS     = 8;
  localparam int SAMPLE_WIDTH = 24;
  localparam int MAX_FADE_MS  = 1000;

  localparam int CH_IDX_W  = $clog2(CHANNELS);
  localparam int GROUP_W   = 4;
  localparam int TRANS_W   = 10;
  localparam int ELAPSED_W = $clog2(MAX_FADE_MS + 1);
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 10;
  localparam int WGT_W     = 16;
  localparam int DIV_STEPS = 4;
  localparam int IDX_W     = 11;

  localparam logic [CFG_IDX_W-1:0] REG_GROUP_CHANNELS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INPUT_GROUP    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_GROUP   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TRANSITION_MS  = 2'd3;

  localparam logic CMD_FRAME = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  localparam logic [GROUP_W-1:0]   GROUP_RESET = 4'd1;
  localparam logic [TRANS_W-1:0]   TRANS_RESET = 10'd100;
  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = ELAPSED_W'(MAX_FADE_MS);

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL,
    ST_SUM
  } agr_state_t;

  typedef struct packed {
    logic mul_en;
    logic sum_en;
    logic fade;
  } lane_ctrl_t;

  typedef struct packed {
    logic [GROUP_W-1:0] gc;
    logic [GROUP_W-1:0] in_g;
    logic [GROUP_W-1:0] out_g;
    logic [GROUP_W-1:0] prev_in_g;
    logic [GROUP_W-1:0] prev_out_g;
  } route_t;

endpackage
`default_nettype wire

// ===== src/agr_in_if.sv =====
// Input channel: audio frame or millisecond tick, valid/ready handshake.
`default_nettype none
interface agr_in_if;
  logic                  valid;
  logic                  ready;
  logic                  cmd;
  agr_pkg::sample_t      in_ch0;
  agr_pkg::sample_t      in_ch1;
  agr_pkg::sample_t      in_ch2;
  agr_pkg::sample_t      in_ch3;
  agr_pkg::sample_t      in_ch4;
  agr_pkg::sample_t      in_ch5;
  agr_pkg::sample_t      in_ch6;
  agr_pkg::sample_t      in_ch7;

  modport source (output valid, cmd, in_ch0, in_ch1, in_ch2, in_ch3,
                  in_ch4, in_ch5, in_ch6, in_ch7, input ready);
  modport sink   (input valid, cmd, in_ch0, in_ch1, in_ch2, in_ch3,
                  in_ch4, in_ch5, in_ch6, in_ch7, output ready);
endinterface
`default_nettype wire

// ===== src/agr_out_if.sv =====
// Output channel: routed frame plus fade flag, valid/ready handshake.
`default_nettype none
interface agr_out_if;
  logic                  valid;
  logic                  ready;
  agr_pkg::sample_t      out_ch0;
  agr_pkg::sample_t      out_ch1;
  agr_pkg::sample_t      out_ch2;
  agr_pkg::sample_t      out_ch3;
  agr_pkg::sample_t      out_ch4;
  agr_pkg::sample_t      out_ch5;
  agr_pkg::sample_t      out_ch6;
  agr_pkg::sample_t      out_ch7;
  logic                  fading;

  modport source (output valid, out_ch0, out_ch1, out_ch2, out_ch3,
                  out_ch4, out_ch5, out_ch6, out_ch7, fading, input ready);
  modport sink   (input valid, out_ch0, out_ch1, out_ch2, out_ch3,
                  out_ch4, out_ch5, out_ch6, out_ch7, fading, output ready);
endinterface
`default_nettype wire

// ===== src/audio_group_router_crossfade.sv =====
// Top level of the audio group router with linear crossfade.
//
// frame_in carries one word per item: cmd = frame (eight signed samples) or
// cmd = tick (one millisecond gone by; samples ignored, no result).
// frame_out carries one word per frame: eight routed samples and the fade flag.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_data); the
// user must write it only while the block is idle, which the block itself
// does not enforce. A write of either group restarts the fade. A tick is
// taken every cycle while idle. A frame is latched, then the fade weight is
// found by the shared divider (4 quotient bits a cycle), then eight lanes
// register the product in ST_MUL and the rounded, saturated result in
// ST_SUM. No new item is taken until the frame's word has been registered.
// The output word is registered: the next frame is taken and worked on while
// it waits; a stalled receiver holds the second frame at its last stage and
// frame_in.ready stays low until the output register frees.
// Synchronous reset restores the register defaults, ends any fade and empties
// the output register.
`default_nettype none
module audio_group_router_crossfade (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [agr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [agr_pkg::CFG_W-1:0]        cfg_data,
  agr_in_if.sink                                frame_in,
  agr_out_if.source                             frame_out
);

  localparam int GW = agr_pkg::GROUP_W;

  agr_pkg::agr_state_t             state;
  agr_pkg::agr_state_t             state_next;
  logic [GW-1:0]                   group_channels;
  logic [GW-1:0]                   input_group;
  logic [GW-1:0]                   output_group;
  logic [agr_pkg::TRANS_W-1:0]     transition_ms;
  logic [agr_pkg::ELAPSED_W-1:0]   elapsed_ms;
  logic [GW-1:0]                   prev_input_group;
  logic [GW-1:0]                   prev_output_group;
  logic                            fade;
  logic                            fading_res;
  logic                            out_valid;
  logic                            out_free;
  logic                            in_acc;
  logic                            frame_acc;
  logic                            div_done;
  logic [agr_pkg::WGT_W-1:0]       wgt;
  agr_pkg::lane_ctrl_t             ctrl;
  agr_pkg::route_t                 routes;
  agr_pkg::sample_t                smp      [agr_pkg::CHANNELS];
  agr_pkg::sample_t                lane_res [agr_pkg::CHANNELS];

  assign out_free  = !out_valid || frame_out.ready;
  assign in_acc    = frame_in.valid && frame_in.ready;
  assign frame_acc = in_acc && (frame_in.cmd == agr_pkg::CMD_FRAME);

  always_comb begin
    state_next = state;
    case (state)
      agr_pkg::ST_IDLE: if (frame_acc) state_next = agr_pkg::ST_DIV;
      agr_pkg::ST_DIV:  if (div_done) state_next = agr_pkg::ST_MUL;
      agr_pkg::ST_MUL:  state_next = agr_pkg::ST_SUM;
      agr_pkg::ST_SUM:  if (out_free) state_next = agr_pkg::ST_IDLE;
      default:          state_next = agr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    frame_in.ready = 1'b0;
    ctrl.mul_en    = 1'b0;
    ctrl.sum_en    = 1'b0;
    ctrl.fade      = fade;
    case (state)
      agr_pkg::ST_IDLE: frame_in.ready = 1'b1;
      agr_pkg::ST_MUL:  ctrl.mul_en = 1'b1;
      agr_pkg::ST_SUM:  ctrl.sum_en = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= agr_pkg::ST_IDLE;
      group_channels    <= agr_pkg::GROUP_RESET;
      input_group       <= agr_pkg::GROUP_RESET;
      output_group      <= agr_pkg::GROUP_RESET;
      transition_ms     <= agr_pkg::TRANS_RESET;
      elapsed_ms        <= agr_pkg::ELAPSED_MAX;
      prev_input_group  <= agr_pkg::GROUP_RESET;
      prev_output_group <= agr_pkg::GROUP_RESET;
      out_valid         <= 1'b0;
    end else begin
      state <= state_next;
      if (in_acc && (frame_in.cmd == agr_pkg::CMD_TICK) &&
          (elapsed_ms < agr_pkg::ELAPSED_MAX)) begin
        elapsed_ms <= elapsed_ms + 1'b1;
      end
      if (frame_acc && !(elapsed_ms < transition_ms)) begin
        prev_input_group  <= input_group;
        prev_output_group <= output_group;
      end
      if (cfg_we) begin
        case (cfg_index)
          agr_pkg::REG_GROUP_CHANNELS: group_channels <= cfg_data[GW-1:0];
          agr_pkg::REG_INPUT_GROUP: begin
            input_group <= cfg_data[GW-1:0];
            elapsed_ms  <= '0;
          end
          agr_pkg::REG_OUTPUT_GROUP: begin
            output_group <= cfg_data[GW-1:0];
            elapsed_ms   <= '0;
          end
          agr_pkg::REG_TRANSITION_MS: transition_ms <= cfg_data[agr_pkg::TRANS_W-1:0];
          default: ;
        endcase
      end
      if (ctrl.sum_en) begin
        out_valid <= 1'b1;
      end else if (frame_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (frame_acc) begin
      fade   <= (elapsed_ms < transition_ms);
      smp[0] <= frame_in.in_ch0;
      smp[1] <= frame_in.in_ch1;
      smp[2] <= frame_in.in_ch2;
      smp[3] <= frame_in.in_ch3;
      smp[4] <= frame_in.in_ch4;
      smp[5] <= frame_in.in_ch5;
      smp[6] <= frame_in.in_ch6;
      smp[7] <= frame_in.in_ch7;
    end
    if (ctrl.sum_en) begin
      fading_res <= fade;
    end
  end

  agr_divider u_div (
    .clk   (clk),
    .rst   (rst),
    .start (frame_acc),
    .num   (elapsed_ms),
    .den   (transition_ms),
    .quot  (wgt),
    .done  (div_done)
  );

  always_comb begin
    routes.gc         = group_channels;
    routes.in_g       = input_group;
    routes.out_g      = output_group;
    routes.prev_in_g  = prev_input_group;
    routes.prev_out_g = prev_output_group;
  end

  for (genvar g = 0; g < agr_pkg::CHANNELS; g++) begin : g_lane
    agr_lane #(.LANE(g)) u_lane (
      .clk    (clk),
      .ctrl   (ctrl),
      .routes (routes),
      .wgt    (wgt),
      .smp    (smp),
      .res    (lane_res[g])
    );
  end

  assign frame_out.valid   = out_valid;
  assign frame_out.fading  = fading_res;
  assign frame_out.out_ch0 = lane_res[0];
  assign frame_out.out_ch1 = lane_res[1];
  assign frame_out.out_ch2 = lane_res[2];
  assign frame_out.out_ch3 = lane_res[3];
  assign frame_out.out_ch4 = lane_res[4];
  assign frame_out.out_ch5 = lane_res[5];
  assign frame_out.out_ch6 = lane_res[6];
  assign frame_out.out_ch7 = lane_res[7];

endmodule
`default_nettype wire

// ===== src/agr_divider.sv =====
// Restoring divider for the Q0.16 fade weight, several quotient bits a cycle.
`default_nettype none
module agr_divider (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  input  wire logic [agr_pkg::ELAPSED_W-1:0]  num,
  input  wire logic [agr_pkg::TRANS_W-1:0]    den,
  output      logic [agr_pkg::WGT_W-1:0]      quot,
  output      logic                           done
);

  localparam int TW     = agr_pkg::TRANS_W;
  localparam int QW     = agr_pkg::WGT_W;
  localparam int STEPS  = agr_pkg::DIV_STEPS;
  localparam int CYCLES = QW / STEPS;
  localparam int CNT_W  = (CYCLES > 1) ? $clog2(CYCLES) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CYCLES - 1);

  logic [TW-1:0]    rem;
  logic [TW-1:0]    rem_next;
  logic [QW-1:0]    quot_next;
  logic [CNT_W-1:0] cnt;
  logic             busy;

  assign done = busy && (cnt == CNT_LAST);

  always_comb begin
    logic [TW:0] r2;
    logic        qb;
    rem_next  = rem;
    quot_next = quot;
    for (int k = 0; k < STEPS; k++) begin
      r2 = {rem_next, 1'b0};
      qb = (r2 >= {1'b0, den});
      if (qb) begin
        r2 = r2 - {1'b0, den};
      end
      rem_next  = r2[TW-1:0];
      quot_next = {quot_next[QW-2:0], qb};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == CNT_LAST) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= TW'(num);
      quot <= '0;
    end else if (busy) begin
      rem  <= rem_next;
      quot <= quot_next;
    end
  end

endmodule
`default_nettype wire

// ===== src/agr_lane.sv =====
// One output channel: picks new and old route sources; fades blend, round, saturate.
`default_nettype none
module agr_lane #(
  parameter int LANE = 0
) (
  input  wire logic                       clk,
  input  wire agr_pkg::lane_ctrl_t        ctrl,
  input  wire agr_pkg::route_t            routes,
  input  wire logic [agr_pkg::WGT_W-1:0]  wgt,
  input  wire agr_pkg::sample_t           smp [agr_pkg::CHANNELS],
  output      agr_pkg::sample_t           res
);

  localparam int SW     = agr_pkg::SAMPLE_WIDTH;
  localparam int WW     = agr_pkg::WGT_W;
  localparam int IW     = agr_pkg::IDX_W;
  localparam int CIW    = agr_pkg::CH_IDX_W;
  localparam int PROD_W = SW + WW + 2;
  localparam int ACC_W  = PROD_W + 1;
  localparam int R_W    = ACC_W - WW;

  localparam logic signed [IW-1:0]    IDX_ONE  = IW'(1);
  localparam logic signed [IW-1:0]    IDX_ZERO = '0;
  localparam logic signed [IW-1:0]    IDX_CH   = IW'(agr_pkg::CHANNELS);
  localparam logic signed [IW-1:0]    IDX_LANE = IW'(LANE);
  localparam logic signed [ACC_W-1:0] RND      = ACC_W'(1) << (WW - 1);
  localparam logic signed [R_W-1:0]   MAXV     = R_W'({1'b0, {(SW-1){1'b1}}});
  localparam logic signed [R_W-1:0]   MINV     = ~MAXV;

  typedef struct packed {
    logic           hit;
    logic [CIW-1:0] idx;
  } sel_t;

  function automatic sel_t route_sel(input logic [agr_pkg::GROUP_W-1:0] in_g,
                                     input logic [agr_pkg::GROUP_W-1:0] out_g,
                                     input logic [agr_pkg::GROUP_W-1:0] gc);
    logic signed [IW-1:0] gcs;
    logic signed [IW-1:0] d0;
    logic signed [IW-1:0] s0;
    logic signed [IW-1:0] i;
    logic signed [IW-1:0] s;
    sel_t                 r;
    gcs   = $signed(IW'(gc));
    d0    = ($signed(IW'(out_g)) - IDX_ONE) * gcs;
    s0    = ($signed(IW'(in_g)) - IDX_ONE) * gcs;
    i     = IDX_LANE - d0;
    s     = s0 + i;
    r.hit = (i >= IDX_ZERO) && (i < gcs) && (s >= IDX_ZERO) && (s < IDX_CH);
    r.idx = s[CIW-1:0];
    return r;
  endfunction

  sel_t                     sel_new;
  sel_t                     sel_old;
  agr_pkg::sample_t         v_new;
  agr_pkg::sample_t         v_old;
  logic signed [SW:0]       diff;
  logic signed [PROD_W-1:0] prod;
  agr_pkg::sample_t         new_r;
  agr_pkg::sample_t         old_r;
  logic signed [ACC_W-1:0]  acc;
  logic signed [R_W-1:0]    rnd;
  agr_pkg::sample_t         res_next;

  always_comb begin
    sel_new = route_sel(routes.in_g, routes.out_g, routes.gc);
    sel_old = route_sel(routes.prev_in_g, routes.prev_out_g, routes.gc);
    v_new   = sel_new.hit ? smp[sel_new.idx] : '0;
    v_old   = sel_old.hit ? smp[sel_old.idx] : '0;
    diff    = $signed({v_new[SW-1], v_new}) - $signed({v_old[SW-1], v_old});
  end

  // previous route at full scale plus (new - previous) * w
  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod  <= diff * $signed({1'b0, wgt});
      new_r <= v_new;
      old_r <= v_old;
    end
  end

  always_comb begin
    acc = ACC_W'($signed({old_r, {WW{1'b0}}})) + ACC_W'(prod) + RND;
    rnd = $signed(acc[ACC_W-1:WW]);
    if (!ctrl.fade) begin
      res_next = new_r;
    end else if (rnd > MAXV) begin
      res_next = MAXV[SW-1:0];
    end else if (rnd < MINV) begin
      res_next = MINV[SW-1:0];
    end else begin
      res_next = rnd[SW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.sum_en) begin
      res <= res_next;
    end
  end

endmodule
`default_nettype wire

// ===== src/agr_checker.sv =====
// Port-level checks of the router, bound to the top level.
`default_nettype none
module agr_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              in_cmd,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire agr_pkg::sample_t  out_ch0,
  input wire logic              fading
);

  a_reset_empties: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output word present after reset");

  a_word_from_frame: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("output word without a frame in progress");

  a_busy_after_frame: assert property (@(posedge clk) disable iff (rst)
    $fell(in_ready) |-> $past(in_valid && (in_cmd == agr_pkg::CMD_FRAME)))
    else $error("ready dropped without a frame taken");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_ch0) && $stable(fading))
    else $error("stalled output word changed");

endmodule

bind audio_group_router_crossfade agr_checker u_agr_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (frame_in.valid),
  .in_ready  (frame_in.ready),
  .in_cmd    (frame_in.cmd),
  .out_valid (frame_out.valid),
  .out_ready (frame_out.ready),
  .out_ch0   (frame_out.out_ch0),
  .fading    (frame_out.fading)
);
`default_nettype wire

// ===== tb/sv/tb_audio_group_router_crossfade.sv =====
// Self-checking testbench for the audio group router with crossfade.
`timescale 1ns / 1ps
module tb_audio_group_router_crossfade;

  localparam logic [agr_pkg::SAMPLE_WIDTH-1:0] S_MAX =
    {1'b0, {(agr_pkg::SAMPLE_WIDTH-1){1'b1}}};
  localparam logic [agr_pkg::SAMPLE_WIDTH-1:0] S_MIN =
    {1'b1, {(agr_pkg::SAMPLE_WIDTH-1){1'b0}}};
  localparam longint ONE_Q16 = 65536;
  localparam longint SAT_HI = (longint'(1) <<< (agr_pkg::SAMPLE_WIDTH-1)) - 1;
  localparam longint SAT_LO = -SAT_HI - 1;
  localparam int RANDOM_ITEMS = 1000;

  typedef struct packed {
    logic                                                     cmd;
    logic [agr_pkg::CHANNELS-1:0][agr_pkg::SAMPLE_WIDTH-1:0] ch;
  } in_word_t;

  typedef struct packed {
    logic                                                     fading;
    logic [agr_pkg::CHANNELS-1:0][agr_pkg::SAMPLE_WIDTH-1:0] ch;
  } routed_word_t;

  class crossfade_scoreboard;
    logic [agr_pkg::GROUP_W-1:0] gc, in_g, out_g, prev_in, prev_out;
    logic [agr_pkg::TRANS_W-1:0] fade_len;
    int unsigned                 elapsed;
    longint                      mix [agr_pkg::CHANNELS];
    routed_word_t                pending [$];
    int mismatches, frames, fade_frames, ticks, writes, checked;

    function new();
      reset_state();
      mismatches = 0;
      frames = 0;
      fade_frames = 0;
      ticks = 0;
      writes = 0;
      checked = 0;
    endfunction

    function void reset_state();
      gc = agr_pkg::GROUP_RESET;
      in_g = agr_pkg::GROUP_RESET;
      out_g = agr_pkg::GROUP_RESET;
      prev_in = agr_pkg::GROUP_RESET;
      prev_out = agr_pkg::GROUP_RESET;
      fade_len = agr_pkg::TRANS_RESET;
      elapsed = agr_pkg::MAX_FADE_MS;
      pending.delete();
    endfunction

    function void write_reg(logic [agr_pkg::CFG_IDX_W-1:0] idx,
                            logic [agr_pkg::CFG_W-1:0] data);
      writes++;
      case (idx)
        agr_pkg::REG_GROUP_CHANNELS: gc = data[agr_pkg::GROUP_W-1:0];
        agr_pkg::REG_INPUT_GROUP: begin
          in_g = data[agr_pkg::GROUP_W-1:0];
          elapsed = 0;
        end
        agr_pkg::REG_OUTPUT_GROUP: begin
          out_g = data[agr_pkg::GROUP_W-1:0];
          elapsed = 0;
        end
        agr_pkg::REG_TRANSITION_MS: fade_len = data[agr_pkg::TRANS_W-1:0];
        default: ;
      endcase
    endfunction

    // channels outside the frame read as zero and are not written
    function void mix_route(in_word_t w, int src_g, int dst_g, longint wt);
      int s, d, i;
      agr_pkg::sample_t v;
      for (i = 0; i < int'(gc); i++) begin
        s = (src_g - 1) * int'(gc) + i;
        d = (dst_g - 1) * int'(gc) + i;
        if (d >= 0 && d < agr_pkg::CHANNELS && s >= 0 && s < agr_pkg::CHANNELS) begin
          v = w.ch[s];
          mix[d] += longint'(v) * wt;
        end
      end
    endfunction

    function void note_input(in_word_t w);
      routed_word_t due;
      longint wt, r;
      bit fade;
      int i;
      if (w.cmd == agr_pkg::CMD_TICK) begin
        ticks++;
        if (elapsed < agr_pkg::MAX_FADE_MS) elapsed++;
        return;
      end
      frames++;
      for (i = 0; i < agr_pkg::CHANNELS; i++) mix[i] = 0;
      fade = elapsed < fade_len;
      if (fade) begin
        fade_frames++;
        wt = (longint'(elapsed) * ONE_Q16) / longint'(fade_len);
        mix_route(w, in_g, out_g, wt);
        mix_route(w, prev_in, prev_out, ONE_Q16 - wt);
      end else begin
        prev_in = in_g;
        prev_out = out_g;
        mix_route(w, in_g, out_g, ONE_Q16);
      end
      for (i = 0; i < agr_pkg::CHANNELS; i++) begin
        r = (mix[i] + 32768) >>> 16;
        if (r > SAT_HI) r = SAT_HI;
        if (r < SAT_LO) r = SAT_LO;
        due.ch[i] = r[agr_pkg::SAMPLE_WIDTH-1:0];
      end
      due.fading = fade;
      pending.push_back(due);
    endfunction

    function void complain(string field, longint want, longint got);
      mismatches++;
      if (mismatches <= 10)
        $display("ERROR: word %0d %s: expected %0d, got %0d", checked, field, want, got);
    endfunction

    function void check_result(routed_word_t got);
      routed_word_t due;
      int i;
      checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: word %0d arrived with nothing outstanding", checked);
        return;
      end
      due = pending.pop_front();
      for (i = 0; i < agr_pkg::CHANNELS; i++)
        if (got.ch[i] !== due.ch[i])
          complain($sformatf("out_ch%0d", i), agr_pkg::sample_t'(due.ch[i]),
                   agr_pkg::sample_t'(got.ch[i]));
      if (got.fading !== due.fading) complain("fading", due.fading, got.fading);
    endfunction
  endclass

  logic                          clk;
  logic                          rst;
  logic                          cfg_we;
  logic [agr_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [agr_pkg::CFG_W-1:0]     cfg_data;

  agr_in_if  frame_in_bus ();
  agr_out_if frame_out_bus ();

  crossfade_scoreboard sb;
  bit src_gaps;
  bit sink_stalls;
  int random_sent;
  int phases;

  audio_group_router_crossfade uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .frame_in  (frame_in_bus),
    .frame_out (frame_out_bus)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("audio_group_router_crossfade: mismatch");
    $finish;
  end

  always @(posedge clk) begin : observe
    in_word_t     iw;
    routed_word_t ow;
    if (rst) begin
      sb.reset_state();
    end else begin
      if (cfg_we) sb.write_reg(cfg_index, cfg_data);
      if (frame_in_bus.valid && frame_in_bus.ready) begin
        iw.cmd = frame_in_bus.cmd;
        iw.ch[0] = frame_in_bus.in_ch0;
        iw.ch[1] = frame_in_bus.in_ch1;
        iw.ch[2] = frame_in_bus.in_ch2;
        iw.ch[3] = frame_in_bus.in_ch3;
        iw.ch[4] = frame_in_bus.in_ch4;
        iw.ch[5] = frame_in_bus.in_ch5;
        iw.ch[6] = frame_in_bus.in_ch6;
        iw.ch[7] = frame_in_bus.in_ch7;
        sb.note_input(iw);
      end
      if (frame_out_bus.valid && frame_out_bus.ready) begin
        ow.fading = frame_out_bus.fading;
        ow.ch[0] = frame_out_bus.out_ch0;
        ow.ch[1] = frame_out_bus.out_ch1;
        ow.ch[2] = frame_out_bus.out_ch2;
        ow.ch[3] = frame_out_bus.out_ch3;
        ow.ch[4] = frame_out_bus.out_ch4;
        ow.ch[5] = frame_out_bus.out_ch5;
        ow.ch[6] = frame_out_bus.out_ch6;
        ow.ch[7] = frame_out_bus.out_ch7;
        sb.check_result(ow);
      end
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [agr_pkg::SAMPLE_WIDTH-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return S_MAX;
      1: return S_MIN;
      2: return agr_pkg::SAMPLE_WIDTH'(int'($urandom_range(0, 6)) - 3);
      default: return agr_pkg::SAMPLE_WIDTH'($urandom());
    endcase
  endfunction

  function automatic in_word_t rand_word(logic cmd);
    in_word_t w;
    int i;
    w.cmd = cmd;
    for (i = 0; i < agr_pkg::CHANNELS; i++) w.ch[i] = rand_sample();
    return w;
  endfunction

  function automatic in_word_t uniform(logic [agr_pkg::SAMPLE_WIDTH-1:0] val);
    in_word_t w;
    int i;
    w.cmd = agr_pkg::CMD_FRAME;
    for (i = 0; i < agr_pkg::CHANNELS; i++) w.ch[i] = val;
    return w;
  endfunction

  function automatic int unsigned pick_group(int unsigned span);
    int unsigned g;
    if ($urandom_range(0, 99) < 85) g = $urandom_range(1, span);
    else g = $urandom_range(0, 15);
    return ($urandom_range(0, 63) << agr_pkg::GROUP_W) | g;
  endfunction

  function automatic int unsigned pick_fade_len();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 3) return $urandom_range(0, 3);
    if (r < 7) return $urandom_range(4, 30);
    if (r < 9) return $urandom_range(31, 200);
    return $urandom_range(0, 1) ? 1000 : 1023;
  endfunction

  task automatic idle(input int unsigned n);
    frame_in_bus.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic send_word(input in_word_t w);
    frame_in_bus.valid <= 1'b1;
    frame_in_bus.cmd <= w.cmd;
    frame_in_bus.in_ch0 <= w.ch[0];
    frame_in_bus.in_ch1 <= w.ch[1];
    frame_in_bus.in_ch2 <= w.ch[2];
    frame_in_bus.in_ch3 <= w.ch[3];
    frame_in_bus.in_ch4 <= w.ch[4];
    frame_in_bus.in_ch5 <= w.ch[5];
    frame_in_bus.in_ch6 <= w.ch[6];
    frame_in_bus.in_ch7 <= w.ch[7];
    @(posedge clk);
    while (!frame_in_bus.ready) @(posedge clk);
    if (src_gaps && $urandom_range(0, 99) < 30) idle(pick_gap());
  endtask

  // wait for the clock first so the last accepted word is already on the scoreboard
  task automatic drain();
    frame_in_bus.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [agr_pkg::CFG_IDX_W-1:0] idx,
                           input int unsigned val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= agr_pkg::CFG_W'(val);
    @(posedge clk);
  endtask

  task automatic end_cfg();
    cfg_we <= 1'b0;
  endtask

  task automatic random_setup();
    int unsigned gsz, span, r;
    gsz = sb.gc;
    if ($urandom_range(0, 99) < 60) begin
      r = $urandom_range(0, 19);
      gsz = (r == 0) ? 0 : (r == 1) ? $urandom_range(9, 15) : $urandom_range(1, 8);
      write_cfg(agr_pkg::REG_GROUP_CHANNELS,
                ($urandom_range(0, 63) << agr_pkg::GROUP_W) | gsz);
    end
    span = (gsz >= 1 && gsz <= agr_pkg::CHANNELS) ? agr_pkg::CHANNELS / gsz : 1;
    if ($urandom_range(0, 99) < 60) write_cfg(agr_pkg::REG_TRANSITION_MS, pick_fade_len());
    if ($urandom_range(0, 99) < 70) write_cfg(agr_pkg::REG_INPUT_GROUP, pick_group(span));
    if ($urandom_range(0, 99) < 60) write_cfg(agr_pkg::REG_OUTPUT_GROUP, pick_group(span));
    end_cfg();
  endtask

  task automatic random_items(input int n);
    int k;
    for (k = 0; k < n; k++) begin
      if ($urandom_range(0, 99) < 40) send_word(rand_word(agr_pkg::CMD_TICK));
      else send_word(rand_word(agr_pkg::CMD_FRAME));
      random_sent++;
      if ($urandom_range(0, 199) == 0) drain();
    end
  endtask

  // long fade: run the elapsed count into its ceiling
  task automatic long_fade();
    int k;
    src_gaps = 1'b0;
    write_cfg(agr_pkg::REG_TRANSITION_MS, $urandom_range(0, 1) ? 1000 : 1023);
    write_cfg(agr_pkg::REG_OUTPUT_GROUP, sb.out_g);
    end_cfg();
    for (k = 0; k < 1010; k++) begin
      send_word(rand_word(agr_pkg::CMD_TICK));
      random_sent++;
      if (k % 100 == 0) begin
        send_word(rand_word(agr_pkg::CMD_FRAME));
        random_sent++;
      end
    end
    send_word(rand_word(agr_pkg::CMD_FRAME));
    random_sent++;
  endtask

  initial begin : sink_side
    int unsigned hold;
    hold = 0;
    frame_out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold != 0) begin
        hold--;
        frame_out_bus.ready <= 1'b0;
      end else begin
        frame_out_bus.ready <= 1'b1;
        if (sink_stalls && $urandom_range(0, 99) < 25) hold = pick_gap();
      end
    end
  end

  initial begin : stimulus
    in_word_t w;
    int i;
    sb = new();
    src_gaps = 1'b0;
    sink_stalls = 1'b0;
    random_sent = 0;
    phases = 0;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    frame_in_bus.valid <= 1'b0;
    frame_in_bus.cmd <= agr_pkg::CMD_FRAME;
    frame_in_bus.in_ch0 <= '0;
    frame_in_bus.in_ch1 <= '0;
    frame_in_bus.in_ch2 <= '0;
    frame_in_bus.in_ch3 <= '0;
    frame_in_bus.in_ch4 <= '0;
    frame_in_bus.in_ch5 <= '0;
    frame_in_bus.in_ch6 <= '0;
    frame_in_bus.in_ch7 <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // defaults after reset, full scale, tick with junk samples
    send_word(uniform(S_MAX));
    send_word(uniform(S_MIN));
    send_word(rand_word(agr_pkg::CMD_TICK));
    send_word(rand_word(agr_pkg::CMD_FRAME));
    drain();

    // whole frame as one group, zero-length fade
    write_cfg(agr_pkg::REG_GROUP_CHANNELS, 8);
    write_cfg(agr_pkg::REG_TRANSITION_MS, 0);
    write_cfg(agr_pkg::REG_INPUT_GROUP, 1);
    end_cfg();
    w = uniform('0);
    for (i = 0; i < agr_pkg::CHANNELS; i++) w.ch[i] = (i % 2) ? S_MIN : S_MAX;
    send_word(w);
    send_word(rand_word(agr_pkg::CMD_FRAME));
    drain();

    // four-tick fade across to group 2, ending on the last frame
    write_cfg(agr_pkg::REG_GROUP_CHANNELS, 4);
    write_cfg(agr_pkg::REG_TRANSITION_MS, 4);
    write_cfg(agr_pkg::REG_INPUT_GROUP, 2);
    write_cfg(agr_pkg::REG_OUTPUT_GROUP, 1);
    end_cfg();
    send_word(rand_word(agr_pkg::CMD_FRAME));
    send_word(rand_word(agr_pkg::CMD_TICK));
    send_word(rand_word(agr_pkg::CMD_FRAME));
    send_word(rand_word(agr_pkg::CMD_TICK));
    send_word(rand_word(agr_pkg::CMD_FRAME));
    send_word(rand_word(agr_pkg::CMD_TICK));
    send_word(rand_word(agr_pkg::CMD_TICK));
    send_word(rand_word(agr_pkg::CMD_FRAME));
    drain();

    write_cfg(agr_pkg::REG_GROUP_CHANNELS, 0);
    end_cfg();
    send_word(rand_word(agr_pkg::CMD_FRAME));
    drain();

    // groups hanging off either end of the frame
    write_cfg(agr_pkg::REG_GROUP_CHANNELS, 3);
    write_cfg(agr_pkg::REG_TRANSITION_MS, 0);
    write_cfg(agr_pkg::REG_INPUT_GROUP, 3);
    write_cfg(agr_pkg::REG_OUTPUT_GROUP, 0);
    end_cfg();
    send_word(rand_word(agr_pkg::CMD_FRAME));
    drain();
    write_cfg(agr_pkg::REG_OUTPUT_GROUP, 3);
    end_cfg();
    send_word(rand_word(agr_pkg::CMD_FRAME));
    drain();
    write_cfg(agr_pkg::REG_INPUT_GROUP, 15);
    end_cfg();
    send_word(rand_word(agr_pkg::CMD_FRAME));
    drain();

    write_cfg(agr_pkg::REG_GROUP_CHANNELS, 15);
    write_cfg(agr_pkg::REG_INPUT_GROUP, 1);
    write_cfg(agr_pkg::REG_OUTPUT_GROUP, 1);
    end_cfg();
    send_word(rand_word(agr_pkg::CMD_FRAME));
    drain();
    write_cfg(agr_pkg::REG_TRANSITION_MS, 1023);
    write_cfg(agr_pkg::REG_INPUT_GROUP, 1);
    end_cfg();
    send_word(rand_word(agr_pkg::CMD_FRAME));
    send_word(rand_word(agr_pkg::CMD_TICK));
    send_word(rand_word(agr_pkg::CMD_FRAME));

    while (random_sent < RANDOM_ITEMS) begin
      phases++;
      drain();
      src_gaps = $urandom_range(0, 3) != 0;
      sink_stalls = $urandom_range(0, 3) != 0;
      if (phases == 4) begin
        long_fade();
      end else begin
        random_setup();
        random_items($urandom_range(30, 80));
      end
    end

    frame_in_bus.valid <= 1'b0;
    @(posedge clk);
    for (i = 0; i < 20000 && sb.pending.size() != 0; i++) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.pending.size() != 0) begin
      $display("ERROR: %0d routed words never arrived", sb.pending.size());
      sb.mismatches += sb.pending.size();
    end

    $display("Ran %0d frames (%0d mid-fade) and %0d ticks over %0d random phases,",
             sb.frames, sb.fade_frames, sb.ticks, phases);
    $display("with %0d register writes and %0d mismatches.", sb.writes, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("audio_group_router_crossfade: match");
    end else begin
      $display("audio_group_router_crossfade: mismatch");
    end
    $finish;
  end

endmodule
